// ----- rtl/core/matroska_cue_point_extractor_top_defines.svh -----
// Assertion macros for the Matroska cue point extractor.
// Included by the RTL file that carries concurrent checks; needs aclk and aresetn in scope.
`ifndef MATROSKA_CUE_POINT_EXTRACTOR_TOP_DEFINES_SVH
`define MATROSKA_CUE_POINT_EXTRACTOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define MCPE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mcpe check failed: same-cycle implication");

// Next-cycle implication, disabled while in reset.
`define MCPE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mcpe check failed: next-cycle implication");

`endif

// ----- rtl/core/mcpe_pkg.sv -----
// Shared types and constants for the Matroska cue point extractor.
// No dependencies; imported by mcpe_vint and the top level.
`default_nettype none

package mcpe_pkg;

    localparam int ACCUM_BITS = 56;
    localparam int LEFT_BITS  = 4;
    localparam int OUT_BITS   = 216;

    typedef enum logic [11:0] {
        PH_CID     = 12'b0000_0000_0001,
        PH_CLEN    = 12'b0000_0000_0010,
        PH_TID     = 12'b0000_0000_0100,
        PH_TLEN    = 12'b0000_0000_1000,
        PH_TDATA   = 12'b0000_0001_0000,
        PH_BID     = 12'b0000_0010_0000,
        PH_BLEN    = 12'b0000_0100_0000,
        PH_TRACK   = 12'b0000_1000_0000,
        PH_BTC_HI  = 12'b0001_0000_0000,
        PH_BTC_LO  = 12'b0010_0000_0000,
        PH_SKIP    = 12'b0100_0000_0000,
        PH_HALT    = 12'b1000_0000_0000
    } phase_t;

    typedef enum logic [1:0] {
        VINT_PENDING = 2'd0,
        VINT_DONE    = 2'd1,
        VINT_ERROR   = 2'd2
    } vint_status_t;

    typedef struct packed {
        vint_status_t           status;
        logic [ACCUM_BITS-1:0]  accum;
        logic [LEFT_BITS-1:0]   left;
    } vint_res_t;

    localparam logic [2:0] KIND_CUE        = 3'd0;
    localparam logic [2:0] KIND_SKIPPED    = 3'd1;
    localparam logic [2:0] KIND_BAD_CID    = 3'd2;
    localparam logic [2:0] KIND_BAD_TID    = 3'd3;
    localparam logic [2:0] KIND_BAD_BID    = 3'd4;
    localparam logic [2:0] KIND_BAD_LENGTH = 3'd5;

    localparam logic [1:0] CFG_SEGMENT_OFFSET = 2'd0;
    localparam logic [1:0] CFG_VIDEO_TRACK    = 2'd1;
    localparam logic [1:0] CFG_CUE_INTERVAL   = 2'd2;

    localparam logic [7:0] CLUSTER_ID [4] = '{8'h1F, 8'h43, 8'hB6, 8'h75};
    localparam logic [7:0] TIMECODE_ID    = 8'hE7;
    localparam logic [7:0] BLOCK_ID       = 8'hA3;
    localparam logic [ACCUM_BITS-1:0] TIMESTAMP_LEN_MAX = 56'd8;

endpackage

`default_nettype wire

// ----- rtl/core/mcpe_vint.sv -----
// EBML variable-length integer step: decodes one byte of a vint against the running value.
// Depends on mcpe_pkg for the result struct.
`default_nettype none

module mcpe_vint #(
    parameter int LENGTH_BYTES_MAX = 8
) (
    input  logic [7:0]                         data_byte,
    input  logic [mcpe_pkg::ACCUM_BITS-1:0]    accum_in,
    input  logic [mcpe_pkg::LEFT_BITS-1:0]     left_in,
    output mcpe_pkg::vint_res_t                res
);
    import mcpe_pkg::*;

    localparam logic [3:0] LEN_MAX = 4'(LENGTH_BYTES_MAX);

    logic [2:0]           lz;
    logic                 found;
    logic [7:0]           first_mask;
    logic [LEFT_BITS-1:0] left_dec;

    always_comb begin
        lz    = 3'd0;
        found = 1'b0;
        for (int i = 7; i >= 0; i--) begin
            if (!found && data_byte[i]) begin
                found = 1'b1;
                lz    = 3'(7 - i);
            end
        end
    end

    assign first_mask = (8'hFF >> lz) >> 1;
    assign left_dec   = left_in - 4'd1;

    always_comb begin
        res = '{status: VINT_PENDING, accum: accum_in, left: left_in};
        if (left_in == '0) begin
            if (data_byte == 8'd0 || {1'b0, lz} >= LEN_MAX) begin
                res.status = VINT_ERROR;
            end else begin
                res.accum  = ACCUM_BITS'(data_byte & first_mask);
                res.left   = LEFT_BITS'(lz);
                res.status = (lz == 3'd0) ? VINT_DONE : VINT_PENDING;
            end
        end else begin
            res.accum  = {accum_in[ACCUM_BITS-9:0], data_byte};
            res.left   = left_dec;
            res.status = (left_dec == '0) ? VINT_DONE : VINT_PENDING;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/matroska_cue_point_extractor_top.sv -----
// Matroska cue point extractor top level: cluster/SimpleBlock parser and result buffer.
// Depends on mcpe_pkg, mcpe_vint and matroska_cue_point_extractor_top_defines.svh.
`default_nettype none
`include "matroska_cue_point_extractor_top_defines.svh"

// Parses a Matroska cluster stream one byte per item on s_tdata and emits one result item for
// each video-track SimpleBlock (cue or skipped block) and for each format error. Every byte is
// handled in the cycle it is accepted, so the block sustains one byte per clock while s_tready
// is high; the combinational parser logic (vint step, position add, compare) sets this rate. A
// two-entry output stage (result register plus skid register) lets bytes keep flowing while a
// result waits; s_tready drops only when both entries hold results. After a cluster id,
// timecode id or length error the parser halts and ignores all bytes until reset. Configuration
// writes on cfg_we/cfg_addr/cfg_wdata take effect at once and must be made while idle.
module matroska_cue_point_extractor_top #(
    parameter int POSITION_BITS    = 48,
    parameter int LENGTH_BYTES_MAX = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [47:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] byte_value
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [215:0] m_tdata,   // [63:0] cue_time, [111:64] cluster_position,
                                    // [159:112] relative_position, [215:160] track_number
    output logic [2:0]   m_tuser    // [2:0] result_kind
);
    import mcpe_pkg::*;

    localparam int PB = POSITION_BITS;

    logic [47:0]           seg_off_reg;
    logic [7:0]            video_track_reg;
    logic [7:0]            cue_interval_reg;

    phase_t                phase_reg, phase_next;
    logic [PB-1:0]         pos_reg, pos_next;
    logic [PB-1:0]         cluster_start_reg, cluster_start_next;
    logic [PB-1:0]         cluster_end_reg, cluster_end_next;
    logic [PB-1:0]         body_start_reg, body_start_next;
    logic [63:0]           cluster_time_reg, cluster_time_next;
    logic [ACCUM_BITS-1:0] accum_reg, accum_next;
    logic [LEFT_BITS-1:0]  left_reg, left_next;
    logic [PB-1:0]         block_start_reg, block_start_next;
    logic [PB-1:0]         block_end_reg, block_end_next;
    logic [ACCUM_BITS-1:0] track_reg, track_next;
    logic [7:0]            tc_hi_reg, tc_hi_next;
    logic [7:0]            skip_reg, skip_next;
    logic [1:0]            idx_reg, idx_next;

    logic                  m_valid_reg, sk_valid_reg;
    logic                  m_valid_next, sk_valid_next;
    logic [2:0]            m_kind_reg, sk_kind_reg;
    logic [OUT_BITS-1:0]   m_data_reg, sk_data_reg;

    logic                  step;
    logic                  pop;
    logic [PB-1:0]         next_pos;
    logic                  eoc;
    logic                  past_block;
    vint_res_t             vint;
    logic                  res_valid;
    logic [2:0]            res_kind;
    logic [OUT_BITS-1:0]   res_data;
    logic [63:0]           end_wide;
    logic [63:0]           cs_wide;
    logic [63:0]           rel_wide;
    logic [63:0]           cue_time;
    logic [47:0]           cluster_pos;

    mcpe_vint #(
        .LENGTH_BYTES_MAX (LENGTH_BYTES_MAX)
    ) u_vint (
        .data_byte (s_tdata),
        .accum_in  (accum_reg),
        .left_in   (left_reg),
        .res       (vint)
    );

    assign s_tready = !sk_valid_reg;
    assign step     = s_tvalid && s_tready;
    assign pop      = m_valid_reg && m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;

    assign next_pos   = pos_reg + PB'(1);
    assign eoc        = next_pos >= cluster_end_reg;
    assign past_block = next_pos >= block_end_reg;
    assign end_wide   = 64'(next_pos) + 64'(vint.accum);
    assign cs_wide    = 64'(cluster_start_reg);
    assign rel_wide   = 64'(block_start_reg) - 64'(body_start_reg);
    assign cue_time   = cluster_time_reg + {{48{tc_hi_reg[7]}}, tc_hi_reg, s_tdata};
    assign cluster_pos = cs_wide[47:0] + seg_off_reg;

    always_comb begin
        phase_next         = phase_reg;
        pos_next           = pos_reg;
        cluster_start_next = cluster_start_reg;
        cluster_end_next   = cluster_end_reg;
        body_start_next    = body_start_reg;
        cluster_time_next  = cluster_time_reg;
        accum_next         = accum_reg;
        left_next          = left_reg;
        block_start_next   = block_start_reg;
        block_end_next     = block_end_reg;
        track_next         = track_reg;
        tc_hi_next         = tc_hi_reg;
        skip_next          = skip_reg;
        idx_next           = idx_reg;
        res_valid          = 1'b0;
        res_kind           = KIND_CUE;
        res_data           = '0;
        if (step) begin
            pos_next = next_pos;
            unique case (phase_reg)
                PH_CID: begin
                    if (idx_reg == 2'd0) begin
                        cluster_start_next = pos_reg;
                    end
                    if (s_tdata != CLUSTER_ID[idx_reg]) begin
                        phase_next = PH_HALT;
                        res_valid  = 1'b1;
                        res_kind   = KIND_BAD_CID;
                    end else if (idx_reg == 2'd3) begin
                        idx_next   = 2'd0;
                        left_next  = '0;
                        phase_next = PH_CLEN;
                    end else begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
                PH_CLEN: begin
                    if (vint.status == VINT_ERROR) begin
                        phase_next = PH_HALT;
                        res_valid  = 1'b1;
                        res_kind   = KIND_BAD_LENGTH;
                    end else begin
                        accum_next = vint.accum;
                        left_next  = vint.left;
                        if (vint.status == VINT_DONE) begin
                            cluster_end_next = end_wide[PB-1:0];
                            body_start_next  = next_pos;
                            phase_next       = PH_TID;
                        end
                    end
                end
                PH_TID: begin
                    if (s_tdata != TIMECODE_ID) begin
                        phase_next = PH_HALT;
                        res_valid  = 1'b1;
                        res_kind   = KIND_BAD_TID;
                    end else begin
                        left_next  = '0;
                        phase_next = PH_TLEN;
                    end
                end
                PH_TLEN: begin
                    accum_next = vint.accum;
                    left_next  = vint.left;
                    if (vint.status == VINT_ERROR ||
                        (vint.status == VINT_DONE && vint.accum > TIMESTAMP_LEN_MAX)) begin
                        phase_next = PH_HALT;
                        res_valid  = 1'b1;
                        res_kind   = KIND_BAD_LENGTH;
                    end else if (vint.status == VINT_DONE) begin
                        cluster_time_next = '0;
                        if (vint.accum == '0) begin
                            left_next = '0;
                            if (eoc) begin
                                phase_next = PH_CID;
                                idx_next   = 2'd0;
                            end else begin
                                phase_next = PH_BID;
                            end
                        end else begin
                            left_next  = vint.accum[LEFT_BITS-1:0];
                            phase_next = PH_TDATA;
                        end
                    end
                end
                PH_TDATA: begin
                    cluster_time_next = {cluster_time_reg[55:0], s_tdata};
                    left_next         = left_reg - 4'd1;
                    if (left_reg == 4'd1) begin
                        left_next = '0;
                        if (eoc) begin
                            phase_next = PH_CID;
                            idx_next   = 2'd0;
                        end else begin
                            phase_next = PH_BID;
                        end
                    end
                end
                PH_BID: begin
                    block_start_next = pos_reg;
                    if (s_tdata != BLOCK_ID) begin
                        res_valid = 1'b1;
                        res_kind  = KIND_BAD_BID;
                        left_next = '0;
                        if (eoc) begin
                            phase_next = PH_CID;
                            idx_next   = 2'd0;
                        end else begin
                            phase_next = PH_BID;
                        end
                    end else begin
                        left_next  = '0;
                        phase_next = PH_BLEN;
                    end
                end
                PH_BLEN: begin
                    if (vint.status == VINT_ERROR) begin
                        phase_next = PH_HALT;
                        res_valid  = 1'b1;
                        res_kind   = KIND_BAD_LENGTH;
                    end else begin
                        accum_next = vint.accum;
                        left_next  = vint.left;
                        if (vint.status == VINT_DONE) begin
                            block_end_next = end_wide[PB-1:0];
                            left_next      = '0;
                            phase_next     = PH_TRACK;
                        end
                    end
                end
                PH_TRACK: begin
                    if (vint.status == VINT_ERROR) begin
                        phase_next = PH_HALT;
                        res_valid  = 1'b1;
                        res_kind   = KIND_BAD_LENGTH;
                    end else begin
                        accum_next = vint.accum;
                        left_next  = vint.left;
                        if (vint.status == VINT_DONE) begin
                            track_next = vint.accum;
                            if (vint.accum != ACCUM_BITS'(video_track_reg)) begin
                                if (past_block) begin
                                    left_next = '0;
                                    if (eoc) begin
                                        phase_next = PH_CID;
                                        idx_next   = 2'd0;
                                    end else begin
                                        phase_next = PH_BID;
                                    end
                                end else begin
                                    phase_next = PH_SKIP;
                                end
                            end else begin
                                phase_next = PH_BTC_HI;
                            end
                        end
                    end
                end
                PH_BTC_HI: begin
                    tc_hi_next = s_tdata;
                    phase_next = PH_BTC_LO;
                end
                PH_BTC_LO: begin
                    res_valid = 1'b1;
                    res_data  = {track_reg, rel_wide[47:0], cluster_pos, cue_time};
                    if (skip_reg == 8'd0) begin
                        res_kind  = KIND_CUE;
                        skip_next = cue_interval_reg;
                    end else begin
                        res_kind  = KIND_SKIPPED;
                        skip_next = skip_reg - 8'd1;
                    end
                    if (past_block) begin
                        left_next = '0;
                        if (eoc) begin
                            phase_next = PH_CID;
                            idx_next   = 2'd0;
                        end else begin
                            phase_next = PH_BID;
                        end
                    end else begin
                        phase_next = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    if (past_block) begin
                        left_next = '0;
                        if (eoc) begin
                            phase_next = PH_CID;
                            idx_next   = 2'd0;
                        end else begin
                            phase_next = PH_BID;
                        end
                    end
                end
                PH_HALT: begin
                    pos_next = pos_reg;
                end
                default: begin
                    pos_next   = pos_reg;
                    phase_next = PH_HALT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_off_reg       <= '0;
            video_track_reg   <= 8'd1;
            cue_interval_reg  <= 8'd11;
            phase_reg         <= PH_CID;
            pos_reg           <= '0;
            cluster_start_reg <= '0;
            cluster_end_reg   <= '0;
            body_start_reg    <= '0;
            cluster_time_reg  <= '0;
            accum_reg         <= '0;
            left_reg          <= '0;
            block_start_reg   <= '0;
            block_end_reg     <= '0;
            track_reg         <= '0;
            tc_hi_reg         <= '0;
            skip_reg          <= '0;
            idx_reg           <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_SEGMENT_OFFSET: seg_off_reg      <= cfg_wdata;
                    CFG_VIDEO_TRACK:    video_track_reg  <= cfg_wdata[7:0];
                    CFG_CUE_INTERVAL:   cue_interval_reg <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
            phase_reg         <= phase_next;
            pos_reg           <= pos_next;
            cluster_start_reg <= cluster_start_next;
            cluster_end_reg   <= cluster_end_next;
            body_start_reg    <= body_start_next;
            cluster_time_reg  <= cluster_time_next;
            accum_reg         <= accum_next;
            left_reg          <= left_next;
            block_start_reg   <= block_start_next;
            block_end_reg     <= block_end_next;
            track_reg         <= track_next;
            tc_hi_reg         <= tc_hi_next;
            skip_reg          <= skip_next;
            idx_reg           <= idx_next;
        end
    end

    // Output stage: result register plus skid register.
    always_comb begin
        m_valid_next  = m_valid_reg;
        sk_valid_next = sk_valid_reg;
        if (pop) begin
            m_valid_next  = sk_valid_reg;
            sk_valid_next = 1'b0;
        end
        if (res_valid) begin
            if (!m_valid_next) begin
                m_valid_next = 1'b1;
            end else begin
                sk_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            sk_valid_reg <= 1'b0;
        end else begin
            m_valid_reg  <= m_valid_next;
            sk_valid_reg <= sk_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && sk_valid_reg) begin
            m_kind_reg <= sk_kind_reg;
            m_data_reg <= sk_data_reg;
        end
        if (res_valid) begin
            if (!m_valid_reg || (pop && !sk_valid_reg)) begin
                m_kind_reg <= res_kind;
                m_data_reg <= res_data;
            end else begin
                sk_kind_reg <= res_kind;
                sk_data_reg <= res_data;
            end
        end
    end

    `MCPE_ASSERT_IMPL(a_skid_implies_main, sk_valid_reg, m_valid_reg)
    `MCPE_ASSERT_NEXT(a_halt_sticks, phase_reg == PH_HALT, phase_reg == PH_HALT)
    `MCPE_ASSERT_NEXT(a_pos_holds_when_idle, !step, $stable(pos_reg))
    `MCPE_ASSERT_IMPL(a_block_timecode_gives_result, step && phase_reg == PH_BTC_LO, res_valid)
    `MCPE_ASSERT_IMPL(a_kind_in_range, m_valid_reg, m_kind_reg <= KIND_BAD_LENGTH)

endmodule

`default_nettype wire
